// ----- hw/rtl/kmrg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrg_pkg
// Shared types and constants for the k-way merge core.
// ----------------------------------------------------------------------------
package kmrg_pkg;

  localparam int RUNS_DEF      = 8;
  localparam int RUN_DEPTH_DEF = 256;

  // stream word widths (byte padded)
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  localparam logic [3:0] RUNS_IN_USE_RST = 4'd8;

  // command codes carried in in_tuser
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;   // unused code, no effect

  // one queued command
  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         run;
    logic signed [31:0] key;
    logic signed [31:0] pay;
  } kmrg_item_t;

  // one merge result
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] pay;
    logic [2:0]         src;
    logic               empty;
    logic               ovf;
  } kmrg_res_t;

endpackage

// ----- hw/rtl/kmrg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmrg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/kmrg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrg_front
// Input side: unpacks stream words into commands and queues them (2 deep).
// ----------------------------------------------------------------------------
module kmrg_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kmrg_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [1:0]                         in_tuser,
  output logic                               q_valid,
  output kmrg_pkg::kmrg_item_t               q_item,
  input  logic                               q_deq
);

  kmrg_pkg::kmrg_item_t slot_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push;
  logic                 pop;
  kmrg_pkg::kmrg_item_t item;

  // unpack the word
  always_comb begin
    item.cmd = in_tuser;
    item.run = in_tdata[2:0];
    item.key = in_tdata[34:3];
    item.pay = in_tdata[66:35];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_deq && q_valid;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ----- hw/rtl/kmrg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrg_back
// Execution side: loads, clears and pops; scans run heads one run at a time.
// ----------------------------------------------------------------------------
module kmrg_back #(
  parameter int RUNS      = kmrg_pkg::RUNS_DEF,
  parameter int RUN_DEPTH = kmrg_pkg::RUN_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           runs_in_use,
  input  logic                 q_valid,
  input  kmrg_pkg::kmrg_item_t q_item,
  output logic                 q_deq,
  output logic                 res_valid,
  output kmrg_pkg::kmrg_res_t  res,
  input  logic                 res_ready
);

  localparam int RW = $clog2(RUNS);
  localparam int FW = $clog2(RUN_DEPTH + 1);
  localparam int AW = $clog2(RUNS * RUN_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(RUN_DEPTH);
  localparam logic [RW-1:0] LAST_RUN = RW'(RUNS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CMP, ST_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [FW-1:0]      fill_r [RUNS];
  logic [FW-1:0]      head_r [RUNS];
  logic               ovf_r, ovf_nxt;
  logic [RW-1:0]      scan_r, scan_nxt;
  logic               cand_r, cand_nxt;
  logic               found_r, found_nxt;
  logic [RW-1:0]      best_r, best_nxt;
  logic signed [31:0] best_key_r, best_key_nxt;
  logic signed [31:0] best_pay_r, best_pay_nxt;
  logic               res_valid_r, res_valid_nxt;
  kmrg_pkg::kmrg_res_t res_r, res_nxt;

  logic [RW-1:0]      idx;
  logic [FW-1:0]      fill_idx;
  logic [FW-1:0]      head_idx;
  logic               ld_ok;
  logic               do_load;
  logic               do_clear;
  logic               do_adv;
  logic               out_free;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [63:0]        rdata;
  logic signed [31:0] rkey;

  // one shared run index: load target in idle, winning run in emit, scan position otherwise
  always_comb begin
    case (state_r)
      ST_IDLE: idx = RW'(q_item.run);
      ST_EMIT: idx = best_r;
      default: idx = scan_r;
    endcase
  end

  assign fill_idx = fill_r[idx];
  assign head_idx = head_r[idx];
  assign ld_ok    = (32'(q_item.run) < 32'(RUNS));
  assign out_free = !res_valid_r || res_ready;
  assign waddr    = AW'(idx) * DEPTH_A + AW'(fill_idx);
  assign raddr    = AW'(idx) * DEPTH_A + AW'(head_idx);
  assign rkey     = rdata[31:0];

  kmrg_ram #(.WIDTH(64), .DEPTH(RUNS * RUN_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({q_item.pay, q_item.key}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ovf_nxt       = ovf_r;
    scan_nxt      = scan_r;
    cand_nxt      = cand_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_key_nxt  = best_key_r;
    best_pay_nxt  = best_pay_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    q_deq         = 1'b0;
    we            = 1'b0;
    do_load       = 1'b0;
    do_clear      = 1'b0;
    do_adv        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_deq = 1'b1;
          case (q_item.cmd)
            kmrg_pkg::CMD_LOAD: begin
              if (ld_ok) begin
                if (32'(fill_idx) >= 32'(RUN_DEPTH)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  we      = 1'b1;
                  do_load = 1'b1;
                end
              end
            end
            kmrg_pkg::CMD_CLEAR: begin
              do_clear = 1'b1;
              ovf_nxt  = 1'b0;
            end
            kmrg_pkg::CMD_POP: begin
              scan_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cand_nxt  = (32'(scan_r) < 32'(runs_in_use)) && (head_idx < fill_idx);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (cand_r && (!found_r || rkey < best_key_r)) begin
          found_nxt    = 1'b1;
          best_nxt     = scan_r;
          best_key_nxt = rkey;
          best_pay_nxt = rdata[63:32];
        end
        if (scan_r == LAST_RUN) begin
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res_valid_nxt = 1'b1;
          res_nxt.key   = found_r ? best_key_r : '0;
          res_nxt.pay   = found_r ? best_pay_r : '0;
          res_nxt.src   = found_r ? 3'(best_r) : 3'd0;
          res_nxt.empty = !found_r;
          res_nxt.ovf   = ovf_r;
          do_adv        = found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ovf_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      res_valid_r <= res_valid_nxt;
    end
    scan_r     <= scan_nxt;
    cand_r     <= cand_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    best_key_r <= best_key_nxt;
    best_pay_r <= best_pay_nxt;
    res_r      <= res_nxt;
  end

  // per-run fill and head counters
  always_ff @(posedge clk) begin
    for (int i = 0; i < RUNS; i++) begin
      if (!rst_n || do_clear) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end else begin
        if (do_load && idx == RW'(i)) begin
          fill_r[i] <= fill_r[i] + 1'b1;
        end
        if (do_adv && idx == RW'(i)) begin
          head_r[i] <= head_r[i] + 1'b1;
        end
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ----- hw/rtl/kway_merge_with_payload_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_with_payload_core
// Merge stage of an external sort over RUNS sorted runs of key/payload pairs.
// ----------------------------------------------------------------------------
// Words are queued two deep and then executed one at a time. A load or clear
// is done in the idle state of the back end; a pop runs a head scan, which
// reads one run head at a time through the single read port of the entry
// store and compares it with the best so far. Ties go to the lower run; an
// exhausted set of runs gives an empty result. No clearing pass is needed
// after reset.
module kway_merge_with_payload_core #(
  parameter int RUNS      = kmrg_pkg::RUNS_DEF,
  parameter int RUN_DEPTH = kmrg_pkg::RUN_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [3:0]                       cfg_wdata,   // runs_in_use
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // run_index[2:0], key_in[34:3], payload_in[66:35], zero pad
  input  logic [kmrg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                       in_tuser,    // cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // key_out[31:0], payload_out[63:32], source_run[66:64], overflow[67], pad
  output logic [kmrg_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser    // empty_res
);

  logic [3:0]           runs_in_use_r;
  logic                 q_valid;
  logic                 q_deq;
  kmrg_pkg::kmrg_item_t q_item;
  kmrg_pkg::kmrg_res_t  res;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_in_use_r <= kmrg_pkg::RUNS_IN_USE_RST;
    end else if (cfg_we) begin
      runs_in_use_r <= cfg_wdata;
    end
  end

  kmrg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_deq     (q_deq)
  );

  kmrg_back #(.RUNS(RUNS), .RUN_DEPTH(RUN_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .runs_in_use (runs_in_use_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_deq       (q_deq),
    .res_valid   (out_tvalid),
    .res         (res),
    .res_ready   (out_tready)
  );

  assign out_tdata = {4'd0, res.ovf, res.src, res.pay, res.key};
  assign out_tuser = res.empty;

endmodule

// ----- hw/rtl/kmrg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrg_checker
// Port-level checks for the merge core, bound to the top level.
// ----------------------------------------------------------------------------
module kmrg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  // nothing comes out in the cycle after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word right after reset");

  // empty result carries zero key, payload and run
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[66:0] == 67'd0)
    else $error("empty result with nonzero fields");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind kway_merge_with_payload_core kmrg_checker u_kmrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- sim/kmrg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrg_scoreboard
// Watches the merge core's command and result streams, keeps its own copy of
// the run stores, predicts each pop result and compares it field by field.
// ----------------------------------------------------------------------------
module kmrg_scoreboard #(
  parameter int RUNS      = kmrg_pkg::RUNS_DEF,
  parameter int RUN_DEPTH = kmrg_pkg::RUN_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [3:0]                       cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [kmrg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [kmrg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tuser,
  output int                               fail_count,
  output int                               pending_pops
);

  logic signed [31:0]  run_keys [RUNS*RUN_DEPTH];
  logic signed [31:0]  run_pays [RUNS*RUN_DEPTH];
  int                  fill_cnt [RUNS];
  int                  head_cnt [RUNS];
  logic                ovf_sticky;
  logic [3:0]          active_runs;
  kmrg_pkg::kmrg_res_t pop_queue[$];

  // next pop result from the current run state; advances the winning run
  function automatic kmrg_pkg::kmrg_res_t merge_pop();
    kmrg_pkg::kmrg_res_t r;
    int                  lim;
    int                  best;
    lim  = (active_runs > RUNS) ? RUNS : active_runs;
    best = -1;
    for (int i = 0; i < lim; i++) begin
      if (head_cnt[i] < fill_cnt[i]) begin
        if (best < 0 || run_keys[i*RUN_DEPTH+head_cnt[i]] <
            run_keys[best*RUN_DEPTH+head_cnt[best]]) best = i;
      end
    end
    r = '0;
    r.ovf = ovf_sticky;
    if (best < 0) begin
      r.empty = 1'b1;
    end else begin
      r.key = run_keys[best*RUN_DEPTH+head_cnt[best]];
      r.pay = run_pays[best*RUN_DEPTH+head_cnt[best]];
      r.src = best[2:0];
      head_cnt[best]++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    kmrg_pkg::kmrg_res_t want;
    kmrg_pkg::kmrg_res_t got;
    logic [2:0]          run;
    if (!rst_n) begin
      foreach (fill_cnt[i]) begin
        fill_cnt[i] = 0;
        head_cnt[i] = 0;
      end
      ovf_sticky  = 1'b0;
      active_runs = kmrg_pkg::RUNS_IN_USE_RST;
      pop_queue.delete();
      fail_count   <= 0;
      pending_pops <= 0;
    end else begin
      if (cfg_we) active_runs = cfg_wdata;
      // result word: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        got.key   = out_tdata[31:0];
        got.pay   = out_tdata[63:32];
        got.src   = out_tdata[66:64];
        got.ovf   = out_tdata[67];
        got.empty = out_tuser;
        if (pop_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = pop_queue.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"pop mismatch: exp key %0d pay %0d src %0d empty %0b ovf %0b,",
                        " got key %0d pay %0d src %0d empty %0b ovf %0b"},
                       want.key, want.pay, want.src, want.empty, want.ovf,
                       got.key, got.pay, got.src, got.empty, got.ovf);
            fail_count <= fail_count + 1;
          end
        end
      end
      // command word: update the run model
      if (in_tvalid && in_tready) begin
        run = in_tdata[2:0];
        case (in_tuser)
          kmrg_pkg::CMD_LOAD: begin
            if (run < RUNS) begin
              if (fill_cnt[run] >= RUN_DEPTH) begin
                ovf_sticky = 1'b1;
              end else begin
                run_keys[run*RUN_DEPTH+fill_cnt[run]] = in_tdata[34:3];
                run_pays[run*RUN_DEPTH+fill_cnt[run]] = in_tdata[66:35];
                fill_cnt[run]++;
              end
            end
          end
          kmrg_pkg::CMD_POP: pop_queue = {pop_queue, merge_pop()};
          kmrg_pkg::CMD_CLEAR: begin
            foreach (fill_cnt[i]) begin
              fill_cnt[i] = 0;
              head_cnt[i] = 0;
            end
            ovf_sticky = 1'b0;
          end
          default: ;
        endcase
      end
      pending_pops <= pop_queue.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the k-way merge core: directed corner cases, then random
// load/pop sessions over several run counts, with random stalls both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_CYCLES = 600000;
  localparam int DRAIN_WAIT = 40;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [3:0]                       cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [kmrg_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]                       in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [kmrg_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  int                               fail_count;
  int                               pending_pops;
  int                               cycle_cnt;
  bit                               calm;

  kway_merge_with_payload_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  kmrg_scoreboard u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .fail_count(fail_count),
    .pending_pops(pending_pops)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run-length watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= MAX_CYCLES) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side backpressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // send one command word, with an optional random gap before it
  task automatic send_word(input logic [1:0] cmd, input logic [2:0] run,
                           input logic [31:0] key, input logic [31:0] pay);
    logic rdy;
    while (!calm && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'd0, pay, key, run};
    // in_tready comes from registers only, so it is settled until the edge
    rdy = in_tready;
    @(posedge clk);
    while (!rdy) begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic idle_and_config(input logic [3:0] val);
    in_tvalid <= 1'b0;
    while (pending_pops != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random key, biased toward a few values near zero and near the most negative key so ties happen
  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0:       return $urandom_range(7);
      1:       return 32'h8000_0000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] k;
    int          sent;
    logic [3:0]  cfg_vals [6];
    cfg_vals = '{4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = kmrg_pkg::CMD_LOAD; calm = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, ties, idle run load, out-of-use pop, clear
    send_word(kmrg_pkg::CMD_POP, 3'd0, 0, 0);
    send_word(kmrg_pkg::CMD_LOAD, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(kmrg_pkg::CMD_LOAD, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(kmrg_pkg::CMD_LOAD, 3'd3, 32'd5, 32'hFFFF_FFFF);
    send_word(kmrg_pkg::CMD_LOAD, 3'd5, 32'd5, 32'd1);
    send_word(kmrg_pkg::CMD_NOP, 3'd2, 32'd9, 32'd9);
    repeat (5) send_word(kmrg_pkg::CMD_POP, 3'd0, 0, 0);
    send_word(kmrg_pkg::CMD_LOAD, 3'd6, 32'd1, 32'd2);
    send_word(kmrg_pkg::CMD_CLEAR, 3'd0, 0, 0);
    send_word(kmrg_pkg::CMD_POP, 3'd0, 0, 0);
    idle_and_config(4'd2);
    send_word(kmrg_pkg::CMD_LOAD, 3'd4, 32'd1, 32'd1);
    send_word(kmrg_pkg::CMD_LOAD, 3'd1, 32'hFFFF_FFFF, 32'd3);
    send_word(kmrg_pkg::CMD_POP, 3'd0, 0, 0);
    send_word(kmrg_pkg::CMD_POP, 3'd0, 0, 0);
    // fill run 1 past its depth to raise overflow
    for (int i = 0; i < 257; i++) send_word(kmrg_pkg::CMD_LOAD, 3'd1, i, ~i);
    send_word(kmrg_pkg::CMD_POP, 3'd0, 0, 0);
    send_word(kmrg_pkg::CMD_CLEAR, 3'd0, 0, 0);
    send_word(kmrg_pkg::CMD_POP, 3'd0, 0, 0);

    // random sessions: clear, load mostly sorted runs, then a mix of mostly pops
    sent = 0;
    for (int ph = 0; sent < 1600; ph++) begin
      idle_and_config(cfg_vals[ph % 6]);
      calm = (ph == 2);
      send_word(kmrg_pkg::CMD_CLEAR, 3'd0, 0, 0);
      for (int r = 0; r < 8; r++) begin
        k = rand_key();
        for (int n = $urandom_range(6); n > 0; n--) begin
          if ($urandom_range(9) == 0) k = $urandom;      // out-of-order noise
          else if (k < 32'h7FFF_FFF0 || k[31]) k = k + $urandom_range(2);
          send_word(kmrg_pkg::CMD_LOAD, r[2:0], k, $urandom);
          sent++;
        end
      end
      for (int n = $urandom_range(10, 40); n > 0; n--) begin
        case ($urandom_range(19))
          0:       send_word(kmrg_pkg::CMD_LOAD, 3'($urandom), rand_key(), $urandom);
          1:       send_word(kmrg_pkg::CMD_NOP, 3'($urandom), $urandom, $urandom);
          2:       send_word(kmrg_pkg::CMD_CLEAR, 3'($urandom), $urandom, $urandom);
          default: send_word(kmrg_pkg::CMD_POP, 3'($urandom), $urandom, $urandom);
        endcase
        sent++;
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    while (pending_pops != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/kmrg_pkg.sv
hw/rtl/kmrg_ram.sv
hw/rtl/kmrg_front.sv
hw/rtl/kmrg_back.sv
hw/rtl/kway_merge_with_payload_core.sv
hw/rtl/kmrg_checker.sv
sim/kmrg_checker.sv
sim/tb_top.sv
